FILE: rtl/core/lru_cache_with_expiry_assert.svh
// ----------------------------------------------------------------------------
// LRU cache assertion macros
// Shorthand for clocked, reset-qualified implication checks.
// ----------------------------------------------------------------------------
`ifndef LRU_CACHE_WITH_EXPIRY_ASSERT_SVH
`define LRU_CACHE_WITH_EXPIRY_ASSERT_SVH

// same-cycle implication
`define LRUC_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define LRUC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/lruc_pkg.sv
// ----------------------------------------------------------------------------
// LRU cache package
// Shared field widths, op codes, cell commands and defaults.
// ----------------------------------------------------------------------------
package lruc_pkg;

    // defaults for the top-level parameters
    localparam int CAPACITY_DEF   = 16;
    localparam int KEY_BITS_DEF   = 32;
    localparam int VALUE_BITS_DEF = 64;
    localparam int TIME_BITS_DEF  = 32;

    // fixed port field widths
    localparam int OP_W      = 2;
    localparam int KEY_W     = 32;
    localparam int VALUE_W   = 64;
    localparam int NOW_W     = 32;
    localparam int DATA_W    = 64;
    localparam int TOTAL_W   = 32;
    localparam int MAXENT_W  = 5;
    localparam int TTL_W     = 32;
    localparam int CFG_IDX_W = 1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ENTRIES = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TTL         = 1'd1;

    typedef enum logic [OP_W-1:0] {
        OP_GET   = 2'd0,
        OP_PUT   = 2'd1,
        OP_INVAL = 2'd2,
        OP_CLEAR = 2'd3
    } op_t;

    // what a cell loads on the update cycle
    typedef enum logic [2:0] {
        CELL_HOLD  = 3'd0,
        CELL_PREV  = 3'd1,  // take neighbour towards the head
        CELL_NEXT  = 3'd2,  // take neighbour towards the tail
        CELL_HEAD  = 3'd3,  // load the head bus
        CELL_CLEAR = 3'd4
    } cell_cmd_t;

    typedef struct packed {
        logic match;
        logic expired;
    } cell_stat_t;

endpackage

FILE: rtl/core/lruc_cell.sv
// ----------------------------------------------------------------------------
// LRU cache cell
// One entry of the recency chain: tag compare, age check and neighbour load.
// ----------------------------------------------------------------------------
module lruc_cell #(
    parameter int KEY_BITS   = 32,
    parameter int VALUE_BITS = 64,
    parameter int TIME_BITS  = 32,
    parameter int ENT_W      = 1 + KEY_BITS + VALUE_BITS + TIME_BITS
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  lruc_pkg::cell_cmd_t      cmd,
    input  logic [ENT_W-1:0]         prev_ent,
    input  logic [ENT_W-1:0]         next_ent,
    input  logic [ENT_W-1:0]         head_ent,
    input  logic [KEY_BITS-1:0]      req_tag,
    input  logic [TIME_BITS-1:0]     req_now,
    input  logic [lruc_pkg::TTL_W-1:0] ttl,
    output logic [ENT_W-1:0]         ent,
    output lruc_pkg::cell_stat_t     stat
);
    import lruc_pkg::*;

    localparam int PAY_W = KEY_BITS + VALUE_BITS + TIME_BITS;
    localparam int AGE_W = (TIME_BITS > TTL_W) ? TIME_BITS : TTL_W;

    logic             valid_reg, valid_next;
    logic [PAY_W-1:0] pay_reg, pay_next;
    logic [TIME_BITS-1:0] age;

    always_comb begin
        valid_next = valid_reg;
        pay_next   = pay_reg;
        unique case (cmd)
            CELL_HOLD: begin
                valid_next = valid_reg;
            end
            CELL_PREV: begin
                valid_next = prev_ent[ENT_W-1];
                pay_next   = prev_ent[PAY_W-1:0];
            end
            CELL_NEXT: begin
                valid_next = next_ent[ENT_W-1];
                pay_next   = next_ent[PAY_W-1:0];
            end
            CELL_HEAD: begin
                valid_next = head_ent[ENT_W-1];
                pay_next   = head_ent[PAY_W-1:0];
            end
            CELL_CLEAR: begin
                valid_next = 1'b0;
            end
            default: begin
                valid_next = valid_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pay_reg <= pay_next;
    end

    // wrapping age against the stamp, low bits hold the stamp
    assign age = req_now - pay_reg[TIME_BITS-1:0];

    assign stat.match   = valid_reg && (pay_reg[PAY_W-1 -: KEY_BITS] == req_tag);
    assign stat.expired = (ttl != '0) && (AGE_W'(age) > AGE_W'(ttl));

    assign ent = {valid_reg, pay_reg};

endmodule

FILE: rtl/core/lru_cache_with_expiry.sv
// ----------------------------------------------------------------------------
// LRU cache with expiry
// Fully associative key/value cache, recency-ordered chain of cells.
// ----------------------------------------------------------------------------
// The cache is a row of CAPACITY cells kept in recency order: cell 0 holds the
// most recent entry and the valid entries always fill cells 0 to live-1, so
// the least recent one sits at the end of the filled run. Each word on the
// slave side passes through a lookup and then an update: in the lookup every
// cell compares its tag with the key and checks its own age against ttl in
// parallel; in the update the row is reordered in one step, cells shifting
// by one place to a neighbour (move to front, removal, insertion with
// eviction) and the result is loaded into the output register. A new word is
// accepted in the same cycle that the previous one completes; a result that
// is not taken holds the block in its update. Valid bits clear at reset, no
// clearing pass. Configuration writes are taken at any time and are meant for
// when the block is idle.
// ----------------------------------------------------------------------------
`include "lru_cache_with_expiry_assert.svh"

module lru_cache_with_expiry #(
    parameter int CAPACITY   = lruc_pkg::CAPACITY_DEF,
    parameter int KEY_BITS   = lruc_pkg::KEY_BITS_DEF,
    parameter int VALUE_BITS = lruc_pkg::VALUE_BITS_DEF,
    parameter int TIME_BITS  = lruc_pkg::TIME_BITS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // configuration
    input  logic                            cfg_wr_en,
    input  logic [lruc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [lruc_pkg::TTL_W-1:0]      cfg_wdata,
    // request stream
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [127:0]                    s_tdata,   // key[31:0], value[95:32], now[127:96]
    input  logic [1:0]                      s_tuser,   // op[1:0]
    // result stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [127:0]                    m_tdata,   // data[63:0], hit_total[95:64],
                                                       // miss_total[127:96]
    output logic [0:0]                      m_tuser    // hit[0]
);
    import lruc_pkg::*;

    localparam int ENT_W = 1 + KEY_BITS + VALUE_BITS + TIME_BITS;
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int LIM_W = (CNT_W > MAXENT_W) ? CNT_W : MAXENT_W;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_LOOKUP = 3'b010,
        ST_UPDATE = 3'b100
    } state_t;

    // ---- configuration ------------------------------------------------------
    logic [MAXENT_W-1:0] max_entries_reg;
    logic [TTL_W-1:0]    ttl_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_entries_reg <= MAXENT_W'(16);
            ttl_reg         <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_MAX_ENTRIES: max_entries_reg <= cfg_wdata[MAXENT_W-1:0];
                CFG_TTL:         ttl_reg         <= cfg_wdata;
                default:         ttl_reg         <= ttl_reg;
            endcase
        end
    end

    // ---- handshake and sequencing -------------------------------------------
    state_t state_reg, state_next;
    logic   out_free, upd_go, in_acc;
    logic   m_tvalid_reg, m_tvalid_next;

    assign out_free = !m_tvalid_reg || m_tready;
    assign upd_go   = (state_reg == ST_UPDATE) && out_free;
    assign s_tready = (state_reg == ST_IDLE) || upd_go;
    assign in_acc   = s_tvalid && s_tready;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (s_tvalid) state_next = ST_LOOKUP;
            ST_LOOKUP: state_next = ST_UPDATE;
            ST_UPDATE: begin
                if (out_free) state_next = s_tvalid ? ST_LOOKUP : ST_IDLE;
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    // request word, captured on accept
    op_t                   req_op_reg;
    logic [KEY_BITS-1:0]   req_tag_reg;
    logic [VALUE_BITS-1:0] req_value_reg;
    logic [TIME_BITS-1:0]  req_now_reg;

    always_ff @(posedge aclk) begin
        if (in_acc) begin
            req_op_reg    <= op_t'(s_tuser);
            req_tag_reg   <= KEY_BITS'(s_tdata[KEY_W-1:0]);
            req_value_reg <= VALUE_BITS'(s_tdata[KEY_W +: VALUE_W]);
            req_now_reg   <= TIME_BITS'(s_tdata[KEY_W+VALUE_W +: NOW_W]);
        end
    end

    // ---- cell row -----------------------------------------------------------
    logic [ENT_W-1:0] cell_ent  [CAPACITY];
    cell_cmd_t        cell_cmd  [CAPACITY];
    cell_stat_t       cell_stat [CAPACITY];
    logic [CAPACITY-1:0] cell_valid;
    logic [ENT_W-1:0] head_ent;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [ENT_W-1:0] prev_ent, next_ent;
        if (g == 0) begin : g_first
            assign prev_ent = '0;
        end else begin : g_mid
            assign prev_ent = cell_ent[g-1];
        end
        if (g == CAPACITY - 1) begin : g_last
            assign next_ent = '0;   // tail refills with an empty entry
        end else begin : g_body
            assign next_ent = cell_ent[g+1];
        end

        lruc_cell #(
            .KEY_BITS   (KEY_BITS),
            .VALUE_BITS (VALUE_BITS),
            .TIME_BITS  (TIME_BITS),
            .ENT_W      (ENT_W)
        ) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .cmd      (cell_cmd[g]),
            .prev_ent (prev_ent),
            .next_ent (next_ent),
            .head_ent (head_ent),
            .req_tag  (req_tag_reg),
            .req_now  (req_now_reg),
            .ttl      (ttl_reg),
            .ent      (cell_ent[g]),
            .stat     (cell_stat[g])
        );

        assign cell_valid[g] = cell_ent[g][ENT_W-1];
    end

    // ---- lookup cycle: collect the matching cell ----------------------------
    logic [CAPACITY-1:0]   lk_match;
    logic                  lk_expired;
    logic [VALUE_BITS-1:0] lk_data;
    logic [TIME_BITS-1:0]  lk_stamp;

    always_comb begin
        lk_expired = 1'b0;
        lk_data    = '0;
        lk_stamp   = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            lk_match[i] = cell_stat[i].match;
            lk_expired  = lk_expired | (cell_stat[i].match & cell_stat[i].expired);
            lk_data     = lk_data  | (cell_stat[i].match ?
                                      cell_ent[i][TIME_BITS +: VALUE_BITS] : '0);
            lk_stamp    = lk_stamp | (cell_stat[i].match ?
                                      cell_ent[i][TIME_BITS-1:0] : '0);
        end
    end

    logic [CAPACITY-1:0]   match_reg;
    logic                  expired_reg;
    logic [VALUE_BITS-1:0] hit_data_reg;
    logic [TIME_BITS-1:0]  hit_stamp_reg;

    always_ff @(posedge aclk) begin
        if (state_reg == ST_LOOKUP) begin
            match_reg     <= lk_match;
            expired_reg   <= lk_expired;
            hit_data_reg  <= lk_data;
            hit_stamp_reg <= lk_stamp;
        end
    end

    // ---- update cycle: reorder the row --------------------------------------
    logic                found, hit, do_remove, do_front, do_insert, do_clear, evict;
    logic [LIM_W-1:0]    me_ext, limit;
    logic [CNT_W-1:0]    live_cnt_reg, live_cnt_next;
    logic [CNT_W:0]      shift_lim;
    logic [CAPACITY-1:0] at_or_past;   // cell index >= matching cell

    assign found     = |match_reg;
    assign hit       = (req_op_reg == OP_GET) && found && !expired_reg;
    assign do_remove = found && (((req_op_reg == OP_GET) && expired_reg) ||
                                 (req_op_reg == OP_INVAL));
    assign do_front  = hit || ((req_op_reg == OP_PUT) && found);
    assign do_insert = (req_op_reg == OP_PUT) && !found;
    assign do_clear  = (req_op_reg == OP_CLEAR);

    // limit: zero acts as one, above capacity acts as capacity
    assign me_ext = LIM_W'(max_entries_reg);
    assign limit  = (me_ext == '0) ? LIM_W'(1) :
                    (me_ext > LIM_W'(CAPACITY)) ? LIM_W'(CAPACITY) : me_ext;
    assign evict  = LIM_W'(live_cnt_reg) >= limit;

    // insertion shifts cells 1..live (or 1..live-1 when the tail is evicted)
    assign shift_lim = evict ? (CNT_W+1)'(live_cnt_reg)
                             : (CNT_W+1)'(live_cnt_reg) + (CNT_W+1)'(1);

    assign head_ent = {1'b1, req_tag_reg,
                       (req_op_reg == OP_GET) ? hit_data_reg : req_value_reg,
                       (req_op_reg == OP_GET) ? hit_stamp_reg : req_now_reg};

    always_comb begin
        at_or_past[0] = match_reg[0];
        for (int i = 1; i < CAPACITY; i++) begin
            at_or_past[i] = at_or_past[i-1] | match_reg[i];
        end
    end

    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            cell_cmd[i] = CELL_HOLD;
            if (upd_go) begin
                priority if (do_clear) begin
                    cell_cmd[i] = CELL_CLEAR;
                end else if (do_remove) begin
                    if (at_or_past[i]) cell_cmd[i] = CELL_NEXT;
                end else if (do_front) begin
                    if (i == 0) cell_cmd[i] = CELL_HEAD;
                    else if (!at_or_past[i-1]) cell_cmd[i] = CELL_PREV;
                end else if (do_insert) begin
                    if (i == 0) cell_cmd[i] = CELL_HEAD;
                    else if ((CNT_W+1)'(i) < shift_lim) cell_cmd[i] = CELL_PREV;
                end
            end
        end
    end

    always_comb begin
        live_cnt_next = live_cnt_reg;
        if (upd_go) begin
            priority if (do_clear) live_cnt_next = '0;
            else if (do_remove) live_cnt_next = live_cnt_reg - CNT_W'(1);
            else if (do_insert && !evict) live_cnt_next = live_cnt_reg + CNT_W'(1);
        end
    end

    // ---- counters and output register ---------------------------------------
    logic [TOTAL_W-1:0] hit_cnt_reg, hit_cnt_next, miss_cnt_reg, miss_cnt_next;
    logic [127:0]       m_tdata_reg;
    logic               m_hit_reg;

    always_comb begin
        hit_cnt_next  = hit_cnt_reg;
        miss_cnt_next = miss_cnt_reg;
        if (upd_go && (req_op_reg == OP_GET)) begin
            if (hit) begin
                if (hit_cnt_reg != '1) hit_cnt_next = hit_cnt_reg + TOTAL_W'(1);
            end else begin
                if (miss_cnt_reg != '1) miss_cnt_next = miss_cnt_reg + TOTAL_W'(1);
            end
        end
    end

    assign m_tvalid_next = upd_go ? 1'b1 : (m_tready ? 1'b0 : m_tvalid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            live_cnt_reg <= '0;
            hit_cnt_reg  <= '0;
            miss_cnt_reg <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            live_cnt_reg <= live_cnt_next;
            hit_cnt_reg  <= hit_cnt_next;
            miss_cnt_reg <= miss_cnt_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (upd_go) begin
            m_hit_reg   <= hit;
            m_tdata_reg <= {miss_cnt_next, hit_cnt_next,
                            hit ? DATA_W'(hit_data_reg) : DATA_W'(0)};
        end
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_tdata_reg;
    assign m_tuser[0] = m_hit_reg;

    // ---- checks -------------------------------------------------------------
    `LRUC_ASSERT_SAME(a_live_cnt_tracks_cells, aclk, aresetn, 1'b1, $countones(cell_valid) == int'(live_cnt_reg), "live count differs from valid cells")
    `LRUC_ASSERT_SAME(a_live_cnt_in_range, aclk, aresetn, 1'b1, int'(live_cnt_reg) <= CAPACITY, "live count above capacity")
    `LRUC_ASSERT_SAME(a_single_match, aclk, aresetn, state_reg == ST_UPDATE, $onehot0(match_reg), "key held in more than one cell")
    `LRUC_ASSERT_NEXT(a_accept_to_lookup, aclk, aresetn, in_acc, state_reg == ST_LOOKUP, "accepted word did not enter lookup")
    `LRUC_ASSERT_SAME(a_result_after_update, aclk, aresetn, $rose(m_tvalid_reg), $past(state_reg == ST_UPDATE), "result issued outside update")

endmodule

FILE: tb/testbench.sv
// ----------------------------------------------------------------------------
// LRU cache with expiry: self-checking testbench
// Drives get/put/invalidate/clear words into the cache and checks every result
// word against a typed-in result or a behavioural copy of the cache kept in the
// testbench. A short directed table comes first, then randomised traffic over
// several register settings with random back-pressure on both streams.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import lruc_pkg::*;

    localparam int SLOTS = CAPACITY_DEF;

    // one result word, split into its fields
    typedef struct packed {
        logic                  hit;
        logic [DATA_W-1:0]     data;
        logic [TOTAL_W-1:0]    hit_total;
        logic [TOTAL_W-1:0]    miss_total;
    } cache_reply_t;

    // one row of the directed table: either a register write or a request word,
    // the latter optionally with its result typed in
    typedef struct {
        bit                    is_cfg;
        logic [CFG_IDX_W-1:0]  cfg_idx;
        logic [TTL_W-1:0]      cfg_val;
        op_t                   op;
        logic [KEY_W-1:0]      key;
        logic [VALUE_W-1:0]    value;
        logic [NOW_W-1:0]      now;
        bit                    known;
        cache_reply_t          want;
    } stim_row_t;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [TTL_W-1:0]      cfg_wdata;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [127:0]          s_tdata;    // key[31:0], value[95:32], now[127:96]
    logic [1:0]            s_tuser;    // op[1:0]
    logic                  m_tvalid;
    logic                  m_tready;
    logic [127:0]          m_tdata;    // data[63:0], hit_total[95:64], miss_total[127:96]
    logic [0:0]            m_tuser;    // hit[0]

    lru_cache_with_expiry dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    // 20 ns period
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Behavioural cache: slot contents, recency ranks (0 = most recent),
    // occupancy, saturating totals and the two registers.
    // ------------------------------------------------------------------------
    bit                    slot_valid [SLOTS];
    logic [KEY_W-1:0]      slot_tag   [SLOTS];
    logic [VALUE_W-1:0]    slot_data  [SLOTS];
    logic [NOW_W-1:0]      slot_stamp [SLOTS];
    int unsigned           slot_rank  [SLOTS];
    int unsigned           live_n;
    logic [TOTAL_W-1:0]    hits;
    logic [TOTAL_W-1:0]    misses;
    logic [MAXENT_W-1:0]   limit_reg;
    logic [TTL_W-1:0]      ttl_reg;

    cache_reply_t          pending_replies [$];   // expected result words, oldest first
    int                    error_count;
    int                    src_idle_pct;          // chance in 100 of a gap before a word
    int                    dst_idle_pct;          // chance in 100 of m_tready low

    // move slot s to the head, pushing the more recent ones back by one
    function automatic void promote_slot(int s);
        int unsigned r;
        r = slot_rank[s];
        for (int i = 0; i < SLOTS; i++) begin
            if (slot_valid[i] && i != s && slot_rank[i] < r) slot_rank[i]++;
        end
        slot_rank[s] = 0;
    endfunction

    // free slot s and close the gap it leaves in the order
    function automatic void drop_slot(int s);
        int unsigned r;
        r = slot_rank[s];
        slot_valid[s] = 1'b0;
        for (int i = 0; i < SLOTS; i++) begin
            if (slot_valid[i] && slot_rank[i] > r) slot_rank[i]--;
        end
        if (live_n > 0) live_n--;
    endfunction

    // apply one request to the behavioural cache and return its result word
    task automatic compute_reply(input op_t op, input logic [KEY_W-1:0] key,
                                 input logic [VALUE_W-1:0] value,
                                 input logic [NOW_W-1:0] now, output cache_reply_t r);
        int               slot;
        int               victim;
        int               free_slot;
        int unsigned      limit;
        bit               alive;
        logic [NOW_W-1:0] age;
        // zero behaves as one, anything past the slot count as the slot count
        limit = (limit_reg == 0) ? 1 : ((limit_reg > SLOTS) ? SLOTS : limit_reg);
        slot = -1;
        for (int i = 0; i < SLOTS; i++) begin
            if (slot < 0 && slot_valid[i] && slot_tag[i] == key) slot = i;
        end
        r = '0;
        case (op)
            OP_GET: begin
                alive = (slot >= 0);
                if (alive && ttl_reg != 0) begin
                    age = now - slot_stamp[slot];    // wraps at the stamp width
                    if (age > ttl_reg) alive = 1'b0;
                end
                if (alive) begin
                    r.hit  = 1'b1;
                    r.data = slot_data[slot];
                    if (hits != '1) hits++;
                    promote_slot(slot);
                end else begin
                    // a stale entry goes on the miss
                    if (slot >= 0) drop_slot(slot);
                    if (misses != '1) misses++;
                end
            end
            OP_PUT: begin
                if (slot >= 0) begin
                    // refresh: no age test, totals untouched
                    slot_data[slot]  = value;
                    slot_stamp[slot] = now;
                    promote_slot(slot);
                end else begin
                    // one eviction only, even when the limit has been lowered
                    if (live_n >= limit) begin
                        victim = -1;
                        for (int i = 0; i < SLOTS; i++) begin
                            if (slot_valid[i] &&
                                (victim < 0 || slot_rank[i] >= slot_rank[victim]))
                                victim = i;
                        end
                        if (victim >= 0) drop_slot(victim);
                    end
                    free_slot = -1;
                    for (int i = 0; i < SLOTS; i++) begin
                        if (slot_valid[i]) slot_rank[i]++;
                        else if (free_slot < 0) free_slot = i;
                    end
                    if (free_slot >= 0) begin
                        slot_valid[free_slot] = 1'b1;
                        slot_tag[free_slot]   = key;
                        slot_data[free_slot]  = value;
                        slot_stamp[free_slot] = now;
                        slot_rank[free_slot]  = 0;
                        live_n++;
                    end
                end
            end
            OP_INVAL: begin
                if (slot >= 0) drop_slot(slot);
            end
            default: begin
                // clear keeps both totals
                for (int i = 0; i < SLOTS; i++) slot_valid[i] = 1'b0;
                live_n = 0;
            end
        endcase
        r.hit_total  = hits;
        r.miss_total = misses;
    endtask

    // ------------------------------------------------------------------------
    // Directed table rows
    // ------------------------------------------------------------------------
    function automatic stim_row_t cfg_row(logic [CFG_IDX_W-1:0] idx, logic [TTL_W-1:0] val);
        stim_row_t row;
        row = '{default: '0, op: OP_GET};
        row.is_cfg  = 1'b1;
        row.cfg_idx = idx;
        row.cfg_val = val;
        return row;
    endfunction

    function automatic stim_row_t word_row(op_t op, logic [KEY_W-1:0] key,
                                           logic [VALUE_W-1:0] value, logic [NOW_W-1:0] now);
        stim_row_t row;
        row = '{default: '0, op: OP_GET};
        row.op    = op;
        row.key   = key;
        row.value = value;
        row.now   = now;
        return row;
    endfunction

    // request whose result is obvious; typed in rather than predicted
    function automatic stim_row_t fixed_row(op_t op, logic [KEY_W-1:0] key,
                                            logic [VALUE_W-1:0] value, logic [NOW_W-1:0] now,
                                            logic hit, logic [DATA_W-1:0] data,
                                            logic [TOTAL_W-1:0] ht, logic [TOTAL_W-1:0] mt);
        stim_row_t row;
        row = word_row(op, key, value, now);
        row.known = 1'b1;
        row.want  = '{hit: hit, data: data, hit_total: ht, miss_total: mt};
        return row;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    // present one request word, wait for the handshake, then log its result
    task automatic issue_word(input op_t op, input logic [KEY_W-1:0] key,
                              input logic [VALUE_W-1:0] value, input logic [NOW_W-1:0] now,
                              input bit known, input cache_reply_t typed);
        cache_reply_t predicted;
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {now, value, key};
        s_tuser  <= op;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        // accepted at this edge; the model still has to see typed rows
        compute_reply(op, key, value, now, predicted);
        pending_replies.push_back(known ? typed : predicted);
    endtask

    // register write, only once the cache has drained
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [TTL_W-1:0] val);
        s_tvalid <= 1'b0;
        while (pending_replies.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx == CFG_MAX_ENTRIES) limit_reg = val[MAXENT_W-1:0];
        else                        ttl_reg   = val;
    endtask

    // ------------------------------------------------------------------------
    // Result side: random back-pressure and the field-by-field compare
    // ------------------------------------------------------------------------
    initial begin : reply_checker
        cache_reply_t want;
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) begin
                if (pending_replies.size() == 0) begin
                    $error("result word with nothing expected");
                    error_count++;
                end else begin
                    want = pending_replies.pop_front();
                    if (m_tuser[0] !== want.hit) begin
                        $error("hit: expected %0d, got %0d", want.hit, m_tuser[0]);
                        error_count++;
                    end
                    if (m_tdata[63:0] !== want.data) begin
                        $error("data: expected %h, got %h", want.data, m_tdata[63:0]);
                        error_count++;
                    end
                    if (m_tdata[95:64] !== want.hit_total) begin
                        $error("hit_total: expected %0d, got %0d",
                               want.hit_total, m_tdata[95:64]);
                        error_count++;
                    end
                    if (m_tdata[127:96] !== want.miss_total) begin
                        $error("miss_total: expected %0d, got %0d",
                               want.miss_total, m_tdata[127:96]);
                        error_count++;
                    end
                end
            end
            m_tready <= ($urandom_range(0, 99) >= dst_idle_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin : stimulus
        stim_row_t          directed_rows [$];
        logic [KEY_W-1:0]   key_pool [24];
        logic [NOW_W-1:0]   clock_now;
        logic [KEY_W-1:0]   key;
        op_t                op;
        int                 pick;
        // per-segment register settings, key spread and idling
        int unsigned        seg_max  [6] = '{16, 4, 1, 31, 3, 16};
        logic [TTL_W-1:0]   seg_ttl  [6] = '{0, 30, 32'hFFFF_FFFF, 1, 200, 12};
        int                 seg_pool [6] = '{20, 7, 3, 24, 5, 20};
        int                 seg_src  [6] = '{26, 26, 50, 50, 0, 0};
        int                 seg_dst  [6] = '{50, 50, 26, 26, 0, 0};

        aresetn      <= 1'b0;
        cfg_wr_en    <= 1'b0;
        cfg_index    <= CFG_MAX_ENTRIES;
        cfg_wdata    <= '0;
        s_tvalid     <= 1'b0;
        s_tdata      <= '0;
        s_tuser      <= OP_GET;
        error_count  = 0;
        src_idle_pct = seg_src[0];
        dst_idle_pct = seg_dst[0];

        // cache state after reset
        foreach (slot_valid[i]) begin
            slot_valid[i] = 1'b0;
            slot_rank[i]  = 0;
        end
        live_n    = 0;
        hits      = '0;
        misses    = '0;
        limit_reg = MAXENT_W'(16);
        ttl_reg   = '0;

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        directed_rows = {
            // reset settings: 16 entries, no expiry
            fixed_row(OP_GET,   32'h0000_0000, 64'h0, 32'h0, 1'b0, 64'h0, 0, 1),
            fixed_row(OP_PUT,   32'h0000_0000, 64'h0, 32'h0, 1'b0, 64'h0, 0, 1),
            fixed_row(OP_GET,   32'h0000_0000, 64'h0, 32'h0, 1'b1, 64'h0, 1, 1),
            fixed_row(OP_PUT,   32'hFFFF_FFFF, '1, 32'hFFFF_FFFF, 1'b0, 64'h0, 1, 1),
            fixed_row(OP_GET,   32'hFFFF_FFFF, 64'h0, 32'hFFFF_FFFF, 1'b1, '1, 2, 1),
            // put on a present key rewrites it
            fixed_row(OP_PUT,   32'h0000_0000, 64'h0123_4567_89AB_CDEF, 32'h5,
                      1'b0, 64'h0, 2, 1),
            fixed_row(OP_GET,   32'h0000_0000, 64'h0, 32'h6,
                      1'b1, 64'h0123_4567_89AB_CDEF, 3, 1),
            fixed_row(OP_INVAL, 32'hFFFF_FFFF, 64'hDEAD_BEEF_DEAD_BEEF, 32'h7, 1'b0, 64'h0, 3, 1),
            fixed_row(OP_GET,   32'hFFFF_FFFF, 64'h0, 32'h8, 1'b0, 64'h0, 3, 2),
            // invalidate of a key that is not there
            fixed_row(OP_INVAL, 32'h1234_5678, 64'h0, 32'h9, 1'b0, 64'h0, 3, 2),
            fixed_row(OP_CLEAR, 32'h0000_0000, 64'h0, 32'hA, 1'b0, 64'h0, 3, 2),
            fixed_row(OP_GET,   32'h0000_0000, 64'h0, 32'hB, 1'b0, 64'h0, 3, 3),
            // two entries, ten units of lifetime
            cfg_row(CFG_MAX_ENTRIES, 32'd2),
            cfg_row(CFG_TTL, 32'd10),
            word_row(OP_PUT, 32'hA5A5_0001, 64'h1, 32'd100),
            word_row(OP_PUT, 32'hA5A5_0002, 64'h2, 32'd105),
            word_row(OP_GET, 32'hA5A5_0001, 64'h0, 32'd110),    // age equal to ttl: live
            word_row(OP_PUT, 32'hA5A5_0003, 64'h3, 32'd111),    // evicts the least recent one, 0002
            word_row(OP_GET, 32'hA5A5_0002, 64'h0, 32'd112),
            word_row(OP_GET, 32'hA5A5_0001, 64'h0, 32'd121),    // expired, dropped
            word_row(OP_PUT, 32'hA5A5_0003, 64'h33, 32'd200),   // stale but refreshed
            word_row(OP_GET, 32'hA5A5_0003, 64'h0, 32'd205),
            word_row(OP_PUT, 32'h5A5A_0004, 64'h4, 32'hFFFF_FFFC),
            // limit of zero acts as one, below the two entries held
            cfg_row(CFG_MAX_ENTRIES, 32'd0),
            word_row(OP_PUT, 32'h5A5A_0005, 64'h5, 32'hFFFF_FFFE),
            word_row(OP_GET, 32'h5A5A_0004, 64'h0, 32'h4),       // age across the wrap
            word_row(OP_GET, 32'hA5A5_0003, 64'h0, 32'h4),
            word_row(OP_GET, 32'h5A5A_0004, 64'h0, 32'hF)
        };

        foreach (directed_rows[i]) begin
            if (directed_rows[i].is_cfg) begin
                write_register(directed_rows[i].cfg_idx, directed_rows[i].cfg_val);
            end else begin
                issue_word(directed_rows[i].op, directed_rows[i].key, directed_rows[i].value,
                           directed_rows[i].now, directed_rows[i].known,
                           directed_rows[i].want);
            end
        end

        // random traffic: mostly keys from a small pool so that gets hit,
        // time creeping forward with the odd jump anywhere
        for (int g = 0; g < 6; g++) begin
            write_register(CFG_MAX_ENTRIES, TTL_W'(seg_max[g]));
            write_register(CFG_TTL, seg_ttl[g]);
            src_idle_pct = seg_src[g];
            dst_idle_pct = seg_dst[g];
            foreach (key_pool[i]) key_pool[i] = $urandom;
            clock_now = $urandom;
            for (int n = 0; n < 117; n++) begin
                pick = $urandom_range(0, 99);
                if (pick < 46)      op = OP_GET;
                else if (pick < 86) op = OP_PUT;
                else if (pick < 97) op = OP_INVAL;
                else                op = OP_CLEAR;
                if ($urandom_range(0, 99) < 85) key = key_pool[$urandom_range(0, seg_pool[g] - 1)];
                else                            key = $urandom;
                if ($urandom_range(0, 99) < 3) clock_now = $urandom;
                else                           clock_now = clock_now + $urandom_range(0, 6);
                issue_word(op, key, {$urandom, $urandom}, clock_now, 1'b0, '0);
            end
        end

        // drain, then watch for anything stray
        s_tvalid <= 1'b0;
        while (pending_replies.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (error_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial begin : watchdog
        #20_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+rtl/core
rtl/core/lruc_pkg.sv
rtl/core/lruc_cell.sv
rtl/core/lru_cache_with_expiry.sv
tb/testbench.sv
